// File: rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, constants and helper functions for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Page and bitmap geometry
  localparam int unsigned PAGE_SHIFT       = 12;
  localparam int unsigned PAGES_PER_WORD   = 32;
  localparam int unsigned HIGH_START_PAGE  = 'h100;
  localparam int unsigned HIGH_START_WORD  = HIGH_START_PAGE / PAGES_PER_WORD;
  localparam int unsigned MAP_WORDS_MAX_DEF = 1024;
  localparam logic [31:0] FULL_WORD        = 32'hFFFF_FFFF;

  // Configuration register widths and reset values
  localparam int unsigned CFG_DATA_W      = 20;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam logic [10:0] MAP_WORDS_RESET = 11'd1024;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WORDS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTECT_FIRST = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTECT_LAST  = 2'd2;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ALLOC_LOW   = 3'd0,
    REQ_ALLOC_HIGH  = 3'd1,
    REQ_FREE_PAGE   = 3'd2,
    REQ_FREE_REGION = 3'd3,
    REQ_LOCK_REGION = 3'd4
  } pba_req_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_BOUND,
    ST_SCAN,
    ST_FINISH
  } pba_state_e;

  // Configuration register file contents
  typedef struct packed {
    logic [10:0] map_words;
    logic [19:0] protect_first_page;
    logic [19:0] protect_last_page;
  } pba_cfg_t;

  // One result of a request
  typedef struct packed {
    logic [31:0] result_address;
    logic        success;
  } pba_result_t;

  // Mask with bits lo..hi set (empty when lo > hi)
  function automatic logic [31:0] range_mask(input logic [4:0] lo, input logic [4:0] hi);
    logic [31:0] m;
    for (int i = 0; i < 32; i++) begin
      m[i] = (5'(i) >= lo) && (5'(i) <= hi);
    end
    return m;
  endfunction

  // Index of the lowest clear bit; 31 when the word is full
  function automatic logic [4:0] first_zero(input logic [31:0] word);
    logic [4:0] b;
    b = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (!word[i]) begin
        b = 5'(i);
      end
    end
    return b;
  endfunction

endpackage

// File: rtl/pba_if.sv
// ----------------------------------------------------------------------------
// pba_if
// Request and response channels of the page bitmap allocator.
// ----------------------------------------------------------------------------
interface pba_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] address;
  logic [31:0] region_bytes;

  modport source (output valid, output req_type, output address, output region_bytes,
                  input ready);
  modport sink (input valid, input req_type, input address, input region_bytes,
                output ready);
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic        success;

  modport source (output valid, output result_address, output success, input ready);
  modport sink (input valid, input result_address, input success, output ready);
endinterface

// File: rtl/pba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// pba_bitmap_ram
// Bitmap store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pba_bitmap_ram #(
  parameter int unsigned DEPTH = pba_pkg::MAP_WORDS_MAX_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pba_walker.sv
// ----------------------------------------------------------------------------
// pba_walker
// Request sequencer: works out the word range of a request, then walks it
// one bitmap word per cycle with a read-modify-write over the bitmap store.
// ----------------------------------------------------------------------------
module pba_walker #(
  parameter int unsigned MAP_WORDS_MAX = pba_pkg::MAP_WORDS_MAX_DEF,
  parameter int unsigned AW = (MAP_WORDS_MAX > 1) ? $clog2(MAP_WORDS_MAX) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pba_pkg::pba_cfg_t   cfg_i,
  pba_req_if.sink             req_i,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output logic [31:0]         ram_wdata_o,
  output logic                ram_re_o,
  output logic [AW-1:0]       ram_raddr_o,
  input  logic [31:0]         ram_rdata_i,
  input  logic                rsp_free_i,
  output logic                done_o,
  output pba_pkg::pba_result_t result_o
);

  import pba_pkg::*;

  localparam int unsigned CW = ($clog2(MAP_WORDS_MAX + 1) > 11) ?
                               $clog2(MAP_WORDS_MAX + 1) : 11;
  localparam int unsigned EW = 22;
  localparam logic [15:0] START_HIGH = 16'(HIGH_START_WORD);

  pba_state_e  state_q, state_d;
  logic [2:0]  req_q, req_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] len_q, len_d;
  logic [EW-1:0] end_q, end_d;
  logic [AW-1:0] lo_w_q, lo_w_d, hi_w_q, hi_w_d;
  logic [4:0]  lo_b_q, lo_b_d, hi_b_q, hi_b_d;
  logic [AW-1:0] rd_next_q, rd_next_d;
  logic        rd_more_q, rd_more_d;
  logic        dv_q, dv_d;
  logic [AW-1:0] dw_q, dw_d;
  logic [31:0] res_q, res_d;
  logic        succ_q, succ_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [CW-1:0] map_ext, words_n;
  logic [EW-1:0] limit;
  logic [19:0]   first_pg;
  logic [32:0]   sum_c, lock_s;
  logic [EW-1:0] end_c, last_pg;
  logic          reg_empty;
  logic [15:0]   alloc_start;
  logic          alloc_empty;
  logic [4:0]    seg_lo, seg_hi, prot_lo, prot_hi;
  logic [14:0]   dw_ext;
  logic          prot_on;
  logic [31:0]   rmask, pmask;
  logic [31:0]   free_data, lock_data, alloc_data;
  logic [4:0]    free_bit;
  logic [19:0]   alloc_page;
  pba_req_e      req_e;

  // Words in use, clipped to the store depth
  assign map_ext = CW'(cfg_i.map_words);
  assign words_n = (map_ext > CW'(MAP_WORDS_MAX)) ? CW'(MAP_WORDS_MAX) : map_ext;
  assign limit   = EW'({words_n, 5'b0});

  // Region bounds
  assign first_pg  = addr_q[31:12];
  assign sum_c     = {1'b0, addr_q} + {1'b0, len_q};
  assign lock_s    = sum_c - 33'd1;
  assign end_c     = (end_q < limit) ? end_q : limit;
  assign last_pg   = end_c - EW'(1);
  assign reg_empty = EW'(first_pg) >= end_c;
  assign req_e     = pba_req_e'(req_q);

  // Allocation start word
  assign alloc_start = (req_e == REQ_ALLOC_HIGH) ? START_HIGH : 16'd0;
  assign alloc_empty = words_n <= CW'(alloc_start);

  // Masks for the word now returned by the store
  assign seg_lo  = (dw_q == lo_w_q) ? lo_b_q : 5'd0;
  assign seg_hi  = (dw_q == hi_w_q) ? hi_b_q : 5'd31;
  assign rmask   = range_mask(seg_lo, seg_hi);
  assign dw_ext  = 15'(dw_q);
  assign prot_on = (cfg_i.protect_first_page <= cfg_i.protect_last_page) &&
                   (dw_ext >= cfg_i.protect_first_page[19:5]) &&
                   (dw_ext <= cfg_i.protect_last_page[19:5]);
  assign prot_lo = (dw_ext == cfg_i.protect_first_page[19:5]) ?
                   cfg_i.protect_first_page[4:0] : 5'd0;
  assign prot_hi = (dw_ext == cfg_i.protect_last_page[19:5]) ?
                   cfg_i.protect_last_page[4:0] : 5'd31;
  assign pmask   = prot_on ? range_mask(prot_lo, prot_hi) : 32'd0;

  // Modified word for each request kind
  assign free_data  = ram_rdata_i & ~(rmask & ~pmask);
  assign lock_data  = ram_rdata_i | rmask;
  assign free_bit   = first_zero(ram_rdata_i);
  assign alloc_data = ram_rdata_i | (32'd1 << free_bit);
  assign alloc_page = 20'({dw_q, free_bit});

  assign req_i.ready = (state_q == ST_IDLE);
  assign result_o    = '{result_address: res_q, success: succ_q};

  // Next state and store access
  always_comb begin
    logic stop;
    stop        = 1'b0;
    state_d     = state_q;
    req_d       = req_q;
    addr_d      = addr_q;
    len_d       = len_q;
    end_d       = end_q;
    lo_w_d      = lo_w_q;
    hi_w_d      = hi_w_q;
    lo_b_d      = lo_b_q;
    hi_b_d      = hi_b_q;
    rd_next_d   = rd_next_q;
    rd_more_d   = rd_more_q;
    dv_d        = 1'b0;
    dw_d        = dw_q;
    res_d       = res_q;
    succ_d      = succ_q;
    clr_d       = clr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = dw_q;
    ram_wdata_o = free_data;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_next_q;
    done_o      = 1'b0;

    case (state_q)
      // Fill every word with ones after reset
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = FULL_WORD;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(MAP_WORDS_MAX - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Take a request
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.req_type;
          addr_d  = req_i.address;
          len_d   = req_i.region_bytes;
          state_d = ST_CALC;
        end
      end

      // Work out the exclusive end page
      ST_CALC: begin
        case (req_e)
          REQ_FREE_PAGE:   end_d = EW'(first_pg) + EW'(1);
          REQ_FREE_REGION: end_d = EW'(sum_c[32:12]);
          REQ_LOCK_REGION: begin
            if (len_q == 32'd0) begin
              end_d = EW'(first_pg) + EW'(1);
            end else begin
              end_d = EW'(lock_s[32:12]) + EW'(1);
            end
          end
          default: end_d = '0;
        endcase
        state_d = ST_BOUND;
      end

      // Clip to the map and set up the word walk
      ST_BOUND: begin
        res_d  = 32'd0;
        succ_d = 1'b0;
        case (req_e)
          REQ_ALLOC_LOW, REQ_ALLOC_HIGH: begin
            lo_w_d  = alloc_start[AW-1:0];
            hi_w_d  = AW'(words_n - CW'(1));
            state_d = alloc_empty ? ST_FINISH : ST_SCAN;
          end
          REQ_FREE_PAGE, REQ_FREE_REGION, REQ_LOCK_REGION: begin
            lo_w_d  = AW'(first_pg[19:5]);
            hi_w_d  = AW'(last_pg[20:5]);
            lo_b_d  = first_pg[4:0];
            hi_b_d  = last_pg[4:0];
            state_d = reg_empty ? ST_FINISH : ST_SCAN;
          end
          default: state_d = ST_FINISH;
        endcase
        rd_next_d = lo_w_d;
        rd_more_d = 1'b1;
      end

      // Read ahead one word while the returned word is modified and written
      ST_SCAN: begin
        if (dv_q) begin
          case (req_e)
            REQ_ALLOC_LOW, REQ_ALLOC_HIGH: begin
              if (ram_rdata_i != FULL_WORD) begin
                ram_we_o    = 1'b1;
                ram_wdata_o = alloc_data;
                res_d       = {alloc_page, 12'd0};
                succ_d      = 1'b1;
                stop        = 1'b1;
              end else if (dw_q == hi_w_q) begin
                stop = 1'b1;
              end
            end
            REQ_LOCK_REGION: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = lock_data;
              stop        = (dw_q == hi_w_q);
            end
            default: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = free_data;
              stop        = (dw_q == hi_w_q);
            end
          endcase
        end
        if (rd_more_q && !stop) begin
          ram_re_o  = 1'b1;
          dv_d      = 1'b1;
          dw_d      = rd_next_q;
          rd_next_d = rd_next_q + AW'(1);
          rd_more_d = (rd_next_q != hi_w_q);
        end
        if (stop) begin
          rd_more_d = 1'b0;
          state_d   = ST_FINISH;
        end
      end

      // Hand the result over once the output stage has room
      ST_FINISH: begin
        if (rsp_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      dv_q      <= 1'b0;
      rd_more_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      dv_q      <= dv_d;
      rd_more_q <= rd_more_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    addr_q    <= addr_d;
    len_q     <= len_d;
    end_q     <= end_d;
    lo_w_q    <= lo_w_d;
    hi_w_q    <= hi_w_d;
    lo_b_q    <= lo_b_d;
    hi_b_q    <= hi_b_d;
    rd_next_q <= rd_next_d;
    dw_q      <= dw_d;
    res_q     <= res_d;
    succ_q    <= succ_d;
  end

endmodule

// File: rtl/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap allocator for 4 KiB physical page frames, 32 pages per word.
// ----------------------------------------------------------------------------
// After reset the block fills the bitmap with ones (every page in use) in
// ST_CLEAR; no request is taken then, but configuration writes are. Each
// request then passes through ST_IDLE, ST_CALC and ST_BOUND for setup and
// ST_FINISH for hand-over; a request that walks the bitmap also passes
// through ST_SCAN, which reads its first word ahead; the one read and one
// write port of the bitmap store move one word a cycle: an allocation visits
// the words from its start word up to the first word with a clear bit (at
// most map_words words), a region request visits the words its clipped page
// range spans, a single free or an empty range visits one word or none. One
// request is worked on at a time; the next is accepted while the previous
// result still waits on the response channel.
module page_bitmap_allocator #(
  parameter int unsigned MAP_WORDS_MAX = pba_pkg::MAP_WORDS_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pba_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  pba_req_if.sink                       req_i,
  pba_rsp_if.source                     rsp_o
);

  import pba_pkg::*;

  localparam int unsigned AW = (MAP_WORDS_MAX > 1) ? $clog2(MAP_WORDS_MAX) : 1;

  pba_cfg_t    cfg_q;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        done;
  pba_result_t result;
  logic        rsp_valid_q;
  pba_result_t rsp_q;
  logic        rsp_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_words          <= MAP_WORDS_RESET;
      cfg_q.protect_first_page <= '0;
      cfg_q.protect_last_page  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAP_WORDS:     cfg_q.map_words          <= cfg_wdata_i[10:0];
        REG_PROTECT_FIRST: cfg_q.protect_first_page <= cfg_wdata_i;
        REG_PROTECT_LAST:  cfg_q.protect_last_page  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pba_bitmap_ram #(
    .DEPTH (MAP_WORDS_MAX),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pba_walker #(
    .MAP_WORDS_MAX (MAP_WORDS_MAX),
    .AW            (AW)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_free_i  (rsp_free),
    .done_o      (done),
    .result_o    (result)
  );

  // Output register: load a finished result, drop it when taken
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= result;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.result_address = rsp_q.result_address;
  assign rsp_o.success        = rsp_q.success;

endmodule
